/* src/bfi_pkg.sv */
// Package for the tape-machine interpreter core: sizes, opcode and state
// encodings, and the result record shared by the control and output stage.
// No dependencies.
package bfi_pkg;

    localparam int TAPE_CELLS    = 32768;
    localparam int PROGRAM_DEPTH = 4096;
    localparam int NEST_DEPTH    = 64;

    // Tape address, program address, program count and nesting widths.
    localparam int TP_W = (TAPE_CELLS > 1) ? $clog2(TAPE_CELLS) : 1;
    localparam int PA_W = (PROGRAM_DEPTH > 1) ? $clog2(PROGRAM_DEPTH) : 1;
    localparam int PC_W = $clog2(PROGRAM_DEPTH + 1);
    localparam int SA_W = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
    localparam int ND_W = $clog2(NEST_DEPTH + 1);

    // Partner entry: matched bit above the partner's program address.
    localparam int PE_W = PA_W + 1;

    localparam int CELL_W  = 8;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

    typedef enum logic [2:0] {
        OP_RIGHT = 3'd0,
        OP_LEFT  = 3'd1,
        OP_INC   = 3'd2,
        OP_DEC   = 3'd3,
        OP_OUT   = 3'd4,
        OP_IN    = 3'd5,
        OP_OPEN  = 3'd6,
        OP_CLOSE = 3'd7
    } op_t;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_STEP = 1'b1
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_PAIR_MATE,
        ST_PAIR_SELF
    } state_t;

    typedef struct packed {
        logic              fault;
        logic              halted;
        logic              in_taken;
        logic              out_valid;
        logic [CELL_W-1:0] out_byte;
    } res_t;

endpackage

/* src/bfi_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// Used for the program store, partner table, bracket stack and tape.
// No dependencies.
module bfi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read data holds its value between reads.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* src/bfi_out_stage.sv */
// Two-entry result buffer (output register plus skid entry) for the m_ side.
// Depends on bfi_pkg for the result record.
module bfi_out_stage
    import bfi_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    input  res_t in_res,
    output logic in_ready,
    output logic out_valid,
    output res_t out_res,
    input  logic out_ready
);

    logic out_valid_reg, out_valid_next;
    logic skid_valid_reg, skid_valid_next;
    res_t out_res_reg, out_res_next;
    res_t skid_res_reg, skid_res_next;
    logic pop;

    assign pop      = out_valid_reg && out_ready;
    assign in_ready = !skid_valid_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_res_next    = out_res_reg;
        skid_res_next   = skid_res_reg;
        if (skid_valid_reg) begin
            if (pop) begin
                out_res_next    = skid_res_reg;
                skid_valid_next = 1'b0;
            end
        end else if (in_valid) begin
            if (!out_valid_reg || pop) begin
                out_res_next   = in_res;
                out_valid_next = 1'b1;
            end else begin
                skid_res_next   = in_res;
                skid_valid_next = 1'b1;
            end
        end else if (pop) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_res_reg  <= out_res_next;
        skid_res_reg <= skid_res_next;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule

/* src/bf_interpreter_core.sv */
// Eight-opcode tape machine interpreter. Each input transfer is either a
// program load (tuser = 0) or one execution step (tuser = 1); every input
// transfer yields exactly one result transfer on the m_ side.
//
// A plain load finishes in its accept cycle; a load of a closing bracket that
// pairs with an open one then passes through ST_PAIR_MATE and ST_PAIR_SELF,
// writing both partner entries, before the next input is taken. In a step, the
// opcode, partner entry and tape cell are read from synchronous RAMs in the
// accept cycle and the cell is modified and written back in the next. A step on
// a halted program finishes in the accept cycle. The tape RAM's single write
// port and registered read data set this split of a step.
// Results enter the output buffer at accept for loads and halted steps, else in ST_EXEC.
//
// After reset the block zeroes all TAPE_CELLS (32768) tape cells, one cell per
// cycle, with s_axis_tready low.
//
// Results go through a two-entry buffer, so a stalled receiver does not
// stop the next input from being taken; when both entries are full,
// s_axis_tready stays low until the receiver takes a result.
// Depends on bfi_pkg, bfi_ram and bfi_out_stage.
module bf_interpreter_core
    import bfi_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [2:0] opcode, [10:3] in_byte, [11] in_valid, [15:12] zero
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // [0] command
    input  logic                 s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [7:0] out_byte, [8] out_valid, [9] in_taken, [10] halted, [11] fault,
    // [15:12] zero
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    state_t state_reg, state_next;
    logic [TP_W-1:0]   clr_addr_reg, clr_addr_next;
    logic [PC_W-1:0]   prog_len_reg, prog_len_next;
    logic [PC_W-1:0]   ip_reg, ip_next;
    logic [TP_W-1:0]   tp_reg, tp_next;
    logic [ND_W-1:0]   depth_reg, depth_next;
    logic              fault_reg, fault_next;
    logic [PA_W-1:0]   at_reg, at_next;
    logic [PA_W-1:0]   mate_reg, mate_next;
    logic [CELL_W-1:0] ib_reg, ib_next;
    logic              iv_reg, iv_next;

    // Memory ports.
    logic              prog_we, prog_re;
    logic [PA_W-1:0]   prog_waddr, prog_raddr;
    logic [2:0]        prog_wdata, prog_rdata;
    logic              part_we, part_re;
    logic [PA_W-1:0]   part_waddr, part_raddr;
    logic [PE_W-1:0]   part_wdata, part_rdata;
    logic              stk_we, stk_re;
    logic [SA_W-1:0]   stk_waddr, stk_raddr;
    logic [PA_W-1:0]   stk_wdata, stk_rdata;
    logic              tape_we, tape_re;
    logic [TP_W-1:0]   tape_waddr, tape_raddr;
    logic [CELL_W-1:0] tape_wdata, tape_rdata;

    logic   accept;
    cmd_t   in_cmd;
    op_t    in_op;
    op_t    ex_op;
    logic   res_valid, res_ready;
    res_t   res;
    res_t   m_res;
    logic [PA_W-1:0] at;
    logic [PC_W-1:0] partner_next;

    assign in_cmd = cmd_t'(s_axis_tuser);
    assign in_op  = op_t'(s_axis_tdata[2:0]);
    assign ex_op  = op_t'(prog_rdata);
    assign at     = prog_len_reg[PA_W-1:0];
    assign partner_next = PC_W'(part_rdata[PA_W-1:0]) + PC_W'(1);

    assign s_axis_tready = (state_reg == ST_IDLE) && res_ready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            prog_len_reg <= '0;
            ip_reg       <= '0;
            tp_reg       <= '0;
            depth_reg    <= '0;
            fault_reg    <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            prog_len_reg <= prog_len_next;
            ip_reg       <= ip_next;
            tp_reg       <= tp_next;
            depth_reg    <= depth_next;
            fault_reg    <= fault_next;
        end
    end

    always_ff @(posedge aclk) begin
        at_reg   <= at_next;
        mate_reg <= mate_next;
        ib_reg   <= ib_next;
        iv_reg   <= iv_next;
    end

    always_comb begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        prog_len_next = prog_len_reg;
        ip_next       = ip_reg;
        tp_next       = tp_reg;
        depth_next    = depth_reg;
        fault_next    = fault_reg;
        at_next       = at_reg;
        mate_next     = mate_reg;
        ib_next       = ib_reg;
        iv_next       = iv_reg;

        prog_we    = 1'b0;
        prog_waddr = at;
        prog_wdata = s_axis_tdata[2:0];
        prog_re    = 1'b0;
        prog_raddr = ip_reg[PA_W-1:0];
        part_we    = 1'b0;
        part_waddr = at;
        part_wdata = '0;
        part_re    = 1'b0;
        part_raddr = ip_reg[PA_W-1:0];
        stk_we     = 1'b0;
        stk_waddr  = depth_reg[SA_W-1:0];
        stk_wdata  = at;
        stk_re     = 1'b0;
        stk_raddr  = SA_W'(depth_reg - ND_W'(1));
        tape_we    = 1'b0;
        tape_waddr = tp_reg;
        tape_wdata = '0;
        tape_re    = 1'b0;
        tape_raddr = tp_reg;

        res_valid = 1'b0;
        res       = '0;

        unique case (state_reg)
            ST_CLEAR: begin
                tape_we    = 1'b1;
                tape_waddr = clr_addr_reg;
                tape_wdata = '0;
                if (clr_addr_reg == TP_W'(TAPE_CELLS - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_addr_next = clr_addr_reg + TP_W'(1);
                end
            end

            ST_IDLE: begin
                if (accept) begin
                    if (in_cmd == CMD_LOAD) begin
                        // Loads settle length, depth and fault now; only the partner
                        // writes of a matched closing bracket follow later.
                        res_valid = 1'b1;
                        if (prog_len_reg == PC_W'(PROGRAM_DEPTH)) begin
                            fault_next = 1'b1;
                        end else begin
                            prog_we       = 1'b1;
                            prog_len_next = prog_len_reg + PC_W'(1);
                            if (in_op == OP_CLOSE && depth_reg != '0) begin
                                depth_next = depth_reg - ND_W'(1);
                                stk_re     = 1'b1;
                                at_next    = at;
                                state_next = ST_PAIR_MATE;
                            end else begin
                                part_we = 1'b1;
                                if (in_op == OP_OPEN) begin
                                    if (depth_reg != ND_W'(NEST_DEPTH)) begin
                                        stk_we     = 1'b1;
                                        depth_next = depth_reg + ND_W'(1);
                                    end else begin
                                        fault_next = 1'b1;
                                    end
                                end
                            end
                        end
                        res.halted = (ip_reg >= prog_len_next);
                        res.fault  = fault_next;
                    end else if (ip_reg >= prog_len_reg) begin
                        // Step on a halted program changes nothing.
                        res_valid  = 1'b1;
                        res.halted = 1'b1;
                        res.fault  = fault_reg;
                    end else begin
                        prog_re    = 1'b1;
                        part_re    = 1'b1;
                        tape_re    = 1'b1;
                        ib_next    = s_axis_tdata[10:3];
                        iv_next    = s_axis_tdata[11];
                        state_next = ST_EXEC;
                    end
                end
            end

            ST_EXEC: begin
                ip_next = ip_reg + PC_W'(1);
                unique case (ex_op)
                    OP_RIGHT: begin
                        tp_next = (tp_reg == TP_W'(TAPE_CELLS - 1)) ? '0
                                                                    : tp_reg + TP_W'(1);
                    end
                    OP_LEFT: begin
                        tp_next = (tp_reg == '0) ? TP_W'(TAPE_CELLS - 1)
                                                 : tp_reg - TP_W'(1);
                    end
                    OP_INC: begin
                        tape_we    = 1'b1;
                        tape_wdata = tape_rdata + CELL_W'(1);
                    end
                    OP_DEC: begin
                        tape_we    = 1'b1;
                        tape_wdata = tape_rdata - CELL_W'(1);
                    end
                    OP_OUT: begin
                        res.out_byte  = tape_rdata;
                        res.out_valid = 1'b1;
                    end
                    OP_IN: begin
                        tape_we      = 1'b1;
                        tape_wdata   = iv_reg ? ib_reg : '0;
                        res.in_taken = iv_reg;
                    end
                    OP_OPEN: begin
                        if (tape_rdata == '0) begin
                            ip_next = part_rdata[PA_W] ? partner_next : prog_len_reg;
                        end
                    end
                    OP_CLOSE: begin
                        if (!part_rdata[PA_W]) begin
                            fault_next = 1'b1;
                            ip_next    = prog_len_reg;
                        end else if (tape_rdata != '0) begin
                            ip_next = partner_next;
                        end
                    end
                    default: begin
                    end
                endcase
                res_valid  = 1'b1;
                res.halted = (ip_next >= prog_len_reg);
                res.fault  = fault_next;
                state_next = ST_IDLE;
            end

            ST_PAIR_MATE: begin
                // The opening bracket points forward to this closing one.
                mate_next  = stk_rdata;
                part_we    = 1'b1;
                part_waddr = stk_rdata;
                part_wdata = {1'b1, at_reg};
                state_next = ST_PAIR_SELF;
            end

            ST_PAIR_SELF: begin
                part_we    = 1'b1;
                part_waddr = at_reg;
                part_wdata = {1'b1, mate_reg};
                state_next = ST_IDLE;
            end

            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    bfi_ram #(.WIDTH(3), .DEPTH(PROGRAM_DEPTH)) u_prog_ram (
        .aclk  (aclk),
        .we    (prog_we),
        .waddr (prog_waddr),
        .wdata (prog_wdata),
        .re    (prog_re),
        .raddr (prog_raddr),
        .rdata (prog_rdata)
    );

    bfi_ram #(.WIDTH(PE_W), .DEPTH(PROGRAM_DEPTH)) u_partner_ram (
        .aclk  (aclk),
        .we    (part_we),
        .waddr (part_waddr),
        .wdata (part_wdata),
        .re    (part_re),
        .raddr (part_raddr),
        .rdata (part_rdata)
    );

    bfi_ram #(.WIDTH(PA_W), .DEPTH(NEST_DEPTH)) u_stack_ram (
        .aclk  (aclk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (stk_re),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    bfi_ram #(.WIDTH(CELL_W), .DEPTH(TAPE_CELLS)) u_tape_ram (
        .aclk  (aclk),
        .we    (tape_we),
        .waddr (tape_waddr),
        .wdata (tape_wdata),
        .re    (tape_re),
        .raddr (tape_raddr),
        .rdata (tape_rdata)
    );

    bfi_out_stage u_out_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_res    (res),
        .in_ready  (res_ready),
        .out_valid (m_axis_tvalid),
        .out_res   (m_res),
        .out_ready (m_axis_tready)
    );

    assign m_axis_tdata = {{(M_TDATA_W - $bits(res_t)){1'b0}}, m_res};

endmodule
